/* rtl/tqwsa_pkg.sv */
// ----------------------------------------------------------------------------
// tqwsa_pkg: shared types and codes for the two-queue weighted arbiter
// Request and status codes, field widths and default sizes.
// ----------------------------------------------------------------------------
package tqwsa_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_WIDTH_DEF   = 16;

    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int BURST_W  = 4;

    typedef logic [REQ_W-1:0]    t_req_type;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [BURST_W-1:0]  t_burst;

    // request codes; bit 1 set means serve
    localparam t_req_type REQ_ENQ_NORMAL = 2'd0;
    localparam t_req_type REQ_ENQ_PRIO   = 2'd1;
    localparam t_req_type REQ_SERVE      = 2'd2;

    // result status codes
    localparam t_status ST_QUEUED  = 2'd0;
    localparam t_status ST_DROPPED = 2'd1;
    localparam t_status ST_SERVED  = 2'd2;
    localparam t_status ST_WAIT    = 2'd3;

    localparam t_burst BURST_LIMIT_RST = 4'd3;

endpackage

/* rtl/tqwsa_req_if.sv */
// ----------------------------------------------------------------------------
// tqwsa_req_if: request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface tqwsa_req_if #(
    parameter int TAG_WIDTH = tqwsa_pkg::TAG_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    tqwsa_pkg::t_req_type req_type;
    logic [TAG_WIDTH-1:0] entry_tag;

    modport source (output valid, output req_type, output entry_tag, input ready);
    modport sink   (input valid, input req_type, input entry_tag, output ready);
endinterface

/* rtl/tqwsa_rsp_if.sv */
// ----------------------------------------------------------------------------
// tqwsa_rsp_if: result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface tqwsa_rsp_if #(
    parameter int TAG_WIDTH = tqwsa_pkg::TAG_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    tqwsa_pkg::t_status   status;
    logic [TAG_WIDTH-1:0] served_tag;
    logic                 served_from_priority;

    modport source (output valid, output status, output served_tag,
                    output served_from_priority, input ready);
    modport sink   (input valid, input status, input served_tag,
                    input served_from_priority, output ready);
endinterface

/* rtl/tqwsa_cfg_if.sv */
// ----------------------------------------------------------------------------
// tqwsa_cfg_if: configuration write channel
// Valid/ready write of the priority burst limit register.
// ----------------------------------------------------------------------------
interface tqwsa_cfg_if;
    logic              valid;
    logic              ready;
    tqwsa_pkg::t_burst priority_burst_limit;

    modport source (output valid, output priority_burst_limit, input ready);
    modport sink   (input valid, input priority_burst_limit, output ready);
endinterface

/* rtl/tqwsa_ring.sv */
// ----------------------------------------------------------------------------
// tqwsa_ring: bounded tag FIFO kept as a ring
// Head index and fill count over a memory; the tag at the next head index is
// read ahead into a register, with a bypass for a write to the same entry.
// ----------------------------------------------------------------------------
module tqwsa_ring #(
    parameter int DEPTH     = tqwsa_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH = tqwsa_pkg::TAG_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_pop,
    input  logic [TAG_WIDTH-1:0] i_tag,
    output logic [TAG_WIDTH-1:0] o_head_tag,
    output logic                 o_empty,
    output logic                 o_full
);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    logic [TAG_WIDTH-1:0] r_mem [DEPTH];
    logic [IDX_W-1:0]     r_head;
    logic [IDX_W-1:0]     n_head;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [SUM_W-1:0]     wr_sum;
    logic [IDX_W-1:0]     wr_idx;
    logic                 do_push;
    logic [TAG_WIDTH-1:0] r_rd_tag;
    logic [TAG_WIDTH-1:0] r_byp_tag;
    logic                 r_byp_hit;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign do_push = i_push && !o_full;

    // tail slot = (head + count) mod DEPTH, sum stays below 2*DEPTH
    assign wr_sum = SUM_W'(r_head) + SUM_W'(r_count);
    assign wr_idx = (wr_sum >= SUM_W'(DEPTH)) ? IDX_W'(wr_sum - SUM_W'(DEPTH))
                                              : IDX_W'(wr_sum);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_pop) begin
            n_head  = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end else if (do_push) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[wr_idx] <= i_tag;
        end
        r_rd_tag  <= r_mem[n_head];
        r_byp_hit <= do_push && (wr_idx == n_head);
        r_byp_tag <= i_tag;
    end

    assign o_head_tag = r_byp_hit ? r_byp_tag : r_rd_tag;

    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && i_pop))
        else $error("ring push and pop in the same cycle");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("ring pop while empty");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push |=> r_count == CNT_W'($past(r_count) + 1'b1))
        else $error("ring count did not grow on push");

endmodule

/* rtl/two_queue_weighted_service_arbiter_core.sv */
// An accepted request is loaded into the input register, and its result
// into the result register when the request advances.
// Throughput: one request per cycle; each cycle does one update of the two
// ring heads and the burst counter. A stalled result holds the pipe.
// Reset clears both queues, the burst counter, and sets the limit to 3;
// no clearing pass, the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
// two_queue_weighted_service_arbiter_core: priority/normal tag arbiter
// Two bounded FIFOs of tags; serves priority entries in bursts up to a
// programmable limit before a waiting normal entry is preferred.
// ----------------------------------------------------------------------------
module two_queue_weighted_service_arbiter_core #(
    parameter int QUEUE_DEPTH = tqwsa_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH   = tqwsa_pkg::TAG_WIDTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tqwsa_req_if.sink   i_req,
    tqwsa_rsp_if.source o_rsp,
    tqwsa_cfg_if.sink   i_cfg
);
    // input register
    logic                 r_in_valid;
    tqwsa_pkg::t_req_type r_req;
    logic [TAG_WIDTH-1:0] r_tag;
    logic                 adv;

    // result register
    logic                 r_out_valid;
    tqwsa_pkg::t_status   r_out_status;
    logic [TAG_WIDTH-1:0] r_out_tag;
    logic                 r_out_from_prio;

    tqwsa_pkg::t_burst    r_limit;
    tqwsa_pkg::t_burst    r_burst_cnt;
    tqwsa_pkg::t_burst    n_burst_cnt;
    tqwsa_pkg::t_status   n_status;
    logic [TAG_WIDTH-1:0] n_tag;
    logic                 n_from_prio;

    logic                 push_n, push_p, pop_n, pop_p;
    logic [TAG_WIDTH-1:0] head_n, head_p;
    logic                 empty_n, empty_p, full_n, full_p;
    logic                 below_limit;
    logic                 use_prio;

    assign adv         = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || adv;
    assign i_cfg.ready = 1'b1;

    tqwsa_ring #(.DEPTH(QUEUE_DEPTH), .TAG_WIDTH(TAG_WIDTH)) u_ring_normal (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push_n),
        .i_pop      (pop_n),
        .i_tag      (r_tag),
        .o_head_tag (head_n),
        .o_empty    (empty_n),
        .o_full     (full_n)
    );

    tqwsa_ring #(.DEPTH(QUEUE_DEPTH), .TAG_WIDTH(TAG_WIDTH)) u_ring_prio (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push_p),
        .i_pop      (pop_p),
        .i_tag      (r_tag),
        .o_head_tag (head_p),
        .o_empty    (empty_p),
        .o_full     (full_p)
    );

    assign below_limit = (r_burst_cnt < r_limit);
    assign use_prio    = below_limit ? !empty_p : empty_n;

    always_comb begin
        push_n      = 1'b0;
        push_p      = 1'b0;
        pop_n       = 1'b0;
        pop_p       = 1'b0;
        n_status    = tqwsa_pkg::ST_QUEUED;
        n_tag       = '0;
        n_from_prio = 1'b0;
        n_burst_cnt = r_burst_cnt;
        case (r_req) inside
            tqwsa_pkg::REQ_ENQ_NORMAL: begin
                push_n   = adv;
                n_status = full_n ? tqwsa_pkg::ST_DROPPED : tqwsa_pkg::ST_QUEUED;
            end
            tqwsa_pkg::REQ_ENQ_PRIO: begin
                push_p   = adv;
                n_status = full_p ? tqwsa_pkg::ST_DROPPED : tqwsa_pkg::ST_QUEUED;
            end
            default: begin
                // both serve codes
                if (empty_p && empty_n) begin
                    n_status = tqwsa_pkg::ST_WAIT;
                end else begin
                    n_status = tqwsa_pkg::ST_SERVED;
                    if (use_prio) begin
                        pop_p       = adv;
                        n_tag       = head_p;
                        n_from_prio = 1'b1;
                        // a priority serve past the limit starts a new burst
                        n_burst_cnt = below_limit ? r_burst_cnt + 1'b1
                                                  : tqwsa_pkg::t_burst'(1);
                    end else begin
                        pop_n       = adv;
                        n_tag       = head_n;
                        n_burst_cnt = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_burst_cnt <= '0;
            r_limit     <= tqwsa_pkg::BURST_LIMIT_RST;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_burst_cnt <= n_burst_cnt;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_limit <= i_cfg.priority_burst_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.req_type;
            r_tag <= i_req.entry_tag;
        end
        if (adv) begin
            r_out_status    <= n_status;
            r_out_tag       <= n_tag;
            r_out_from_prio <= n_from_prio;
        end
    end

    assign o_rsp.valid                = r_out_valid;
    assign o_rsp.status               = r_out_status;
    assign o_rsp.served_tag           = r_out_tag;
    assign o_rsp.served_from_priority = r_out_from_prio;

    a_prio_flag_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_from_prio |-> r_out_status == tqwsa_pkg::ST_SERVED)
        else $error("priority flag on a result that is not a serve");

    a_tag_zero_unserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != tqwsa_pkg::ST_SERVED |-> r_out_tag == '0)
        else $error("nonzero tag on a result that is not a serve");

    a_wait_keeps_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_status == tqwsa_pkg::ST_WAIT |=> r_burst_cnt == $past(r_burst_cnt))
        else $error("burst counter changed on a wait");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_req.ready)
        else $error("request not taken while input register is empty");

endmodule
